// ----- hdl/rsc_pkg.sv -----
`timescale 1ns / 1ps
package rsc_pkg;
  localparam int COLOR_BITS = 16;
  localparam int C = COLOR_BITS;
  localparam int DEPTH_BITS = 16;
  localparam int SUM_BITS = C + 4;
  localparam int T_BITS = C + 1;
  localparam int F_BITS = C + 9;
  localparam int IN_DATA_BITS = ((4 * C + DEPTH_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((4 * C + 7) / 8) * 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  // One classified sample, handed from the front part to the back part.
  typedef struct packed {
    logic [C-1:0]        red;
    logic [C-1:0]        green;
    logic [C-1:0]        blue;
    logic [C-1:0]        alpha;
    logic [T_BITS-1:0]   b;
    logic [T_BITS-1:0]   t;
    logic [F_BITS-1:0]   f;
    logic                last;
  } sample_t;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_INT,
    FR_FRAC,
    FR_DIV,
    FR_DONE
  } front_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WEIGHT,
    BK_ACCUM,
    BK_EMIT
  } back_state_t;
endpackage

// ----- hdl/rsc_front.sv -----
`timescale 1ns / 1ps
// Computes T = b^depth and F = (1 - T) / alpha for one sample with a few small
// multipliers, a bit-serial square root and a bit-serial divider.
module rsc_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [rsc_pkg::C-1:0]                red,
  input  logic [rsc_pkg::C-1:0]                green,
  input  logic [rsc_pkg::C-1:0]                blue,
  input  logic [rsc_pkg::C-1:0]                alpha,
  input  logic [rsc_pkg::DEPTH_BITS-1:0]       segment_depth,
  input  logic                                 last_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output rsc_pkg::sample_t                     out_item
);
  localparam int C = rsc_pkg::C;
  localparam int TB = rsc_pkg::T_BITS;
  localparam int RB = 2 * C + 2;
  localparam int NB = 2 * C + 1;
  localparam int CNT_BITS = $clog2(2 * C + 2);

  rsc_pkg::front_state_t state, state_next;
  rsc_pkg::sample_t item;
  logic [TB-1:0] res, sq, r;
  logic [7:0] ip;
  logic [7:0] frac;
  logic [3:0] k;
  logic [CNT_BITS-1:0] cnt;
  // square root registers
  logic [RB-1:0] sr_v, sr_root, sr_bit;
  logic sr_busy;
  // divider registers
  logic [NB-1:0] dv_num;
  logic [C:0]    dv_rem;
  logic [NB-1:0] dv_q;
  // Depth kept for the zero-alpha limit.
  logic [7:0] ip_save, frac_save;

  logic [2*TB-1:0] prod_a, prod_b, prod_r;
  logic [RB-1:0] sr_sum;
  logic [C+1:0] dv_trial;

  assign in_ready  = (state == rsc_pkg::FR_IDLE);
  assign out_valid = (state == rsc_pkg::FR_DONE);
  assign out_item  = item;
  assign prod_a = res * sq;
  assign prod_b = sq * sq;
  assign prod_r = res * sr_root[TB-1:0];
  assign sr_sum = sr_root + sr_bit;
  assign dv_trial = {dv_rem, dv_num[NB-1]} - {1'b0, 1'b0, item.alpha};

  always_comb begin
    state_next = state;
    unique case (state)
      rsc_pkg::FR_IDLE:  if (in_valid) state_next = rsc_pkg::FR_INT;
      rsc_pkg::FR_INT:   if (ip == '0) state_next = rsc_pkg::FR_FRAC;
      rsc_pkg::FR_FRAC:  if (k == 4'd8 && !sr_busy) state_next = rsc_pkg::FR_DIV;
      rsc_pkg::FR_DIV:   if (cnt == CNT_BITS'(NB)) state_next = rsc_pkg::FR_DONE;
      rsc_pkg::FR_DONE:  if (out_ready) state_next = rsc_pkg::FR_IDLE;
      default:           state_next = rsc_pkg::FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= rsc_pkg::FR_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      rsc_pkg::FR_IDLE: begin
        item.red   <= red;
        item.green <= green;
        item.blue  <= blue;
        item.alpha <= alpha;
        item.last  <= last_sample;
        item.b     <= (TB'(1) << C) - TB'(alpha);
        res  <= TB'(1) << C;
        sq   <= (TB'(1) << C) - TB'(alpha);
        r    <= (TB'(1) << C) - TB'(alpha);
        ip   <= segment_depth[15:8];
        frac <= segment_depth[7:0];
        k    <= '0;
        sr_busy <= 1'b0;
        cnt  <= '0;
      end
      rsc_pkg::FR_INT: begin
        if (ip != '0) begin
          if (ip[0]) res <= prod_a[C +: TB];
          sq <= prod_b[C +: TB];
          ip <= ip >> 1;
        end
      end
      rsc_pkg::FR_FRAC: begin
        if (!sr_busy) begin
          if (k != 4'd8) begin
            sr_v    <= RB'(r) << C;
            sr_root <= '0;
            sr_bit  <= RB'(1) << (RB - 2);
            sr_busy <= 1'b1;
          end else begin
            item.t <= res;
            dv_num <= NB'((TB'(1) << C) - res) << C;
            dv_rem <= '0;
            dv_q   <= '0;
            cnt    <= '0;
          end
        end else if (sr_bit == '0) begin
          r <= TB'(sr_root);
          sq <= TB'(sr_root);
          sr_busy <= 1'b0;
          k <= k + 4'd1;
        end else begin
          if (sr_v >= sr_sum) begin
            sr_v    <= sr_v - sr_sum;
            sr_root <= (sr_root >> 1) + sr_bit;
          end else begin
            sr_root <= sr_root >> 1;
          end
          sr_bit <= sr_bit >> 2;
        end
        // Multiply by the new root once it is known.
        if (sr_busy && sr_bit == '0 && frac[3'd7 - k[2:0]]) begin
          res <= prod_r[C +: TB];
        end
      end
      rsc_pkg::FR_DIV: begin
        if (cnt != CNT_BITS'(NB)) begin
          if (!dv_trial[C+1]) begin
            dv_rem <= dv_trial[C:0];
            dv_q   <= {dv_q[NB-2:0], 1'b1};
          end else begin
            dv_rem <= {dv_rem[C-1:0], dv_num[NB-1]};
            dv_q   <= {dv_q[NB-2:0], 1'b0};
          end
          dv_num <= dv_num << 1;
          cnt <= cnt + CNT_BITS'(1);
        end else if (item.alpha == '0) begin
          item.f <= rsc_pkg::F_BITS'({ip_save, frac_save}) << (C - 8);
        end else if (dv_q > NB'(256) << C) begin
          item.f <= rsc_pkg::F_BITS'(256) << C;
        end else begin
          item.f <= rsc_pkg::F_BITS'(dv_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == rsc_pkg::FR_IDLE) begin
      ip_save   <= segment_depth[15:8];
      frac_save <= segment_depth[7:0];
    end
  end
endmodule

// ----- hdl/rsc_queue.sv -----
`timescale 1ns / 1ps
module rsc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  rsc_pkg::sample_t wr_item,
  output logic             rd_valid,
  input  logic             rd_ready,
  output rsc_pkg::sample_t rd_item
);
  localparam int D = rsc_pkg::QUEUE_DEPTH;
  localparam int P = rsc_pkg::QUEUE_PTR_BITS;
  rsc_pkg::sample_t slots [D];
  logic [P-1:0] wp, rp;
  logic [P:0] count;
  logic do_wr, do_rd;

  assign wr_ready = (count != (P+1)'(D));
  assign rd_valid = (count != '0);
  assign rd_item  = slots[rp];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (do_wr) wp <= wp + P'(1);
      if (do_rd) rp <= rp + P'(1);
      count <= count + (P+1)'(do_wr) - (P+1)'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slots[wp] <= wr_item;
  end
endmodule

// ----- hdl/rsc_back.sv -----
`timescale 1ns / 1ps
// Applies one sample to the running sums and the transmittance.
module rsc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rsc_pkg::sample_t              in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rsc_pkg::OUT_DATA_BITS-1:0] out_data
);
  localparam int C = rsc_pkg::C;
  localparam int SB = rsc_pkg::SUM_BITS;
  localparam int TB = rsc_pkg::T_BITS;
  localparam int FB = rsc_pkg::F_BITS;
  localparam logic [SB-1:0] SUM_MAX = '1;

  rsc_pkg::back_state_t state, state_next;
  rsc_pkg::sample_t cur;
  logic [SB-1:0] sum_r, sum_g, sum_b, sum_a;
  logic [TB-1:0] trans;
  logic [TB-1:0] tb;
  logic [FB-1:0] w;
  logic [2*TB-1:0] tb_prod;
  logic [TB+FB-1:0] w_prod;
  logic [2*TB-1:0] t_prod;

  function automatic logic [SB-1:0] acc(input logic [SB-1:0] s,
                                        input logic [C-1:0] c,
                                        input logic [FB-1:0] wt);
    logic [C+FB-1:0] p;
    logic [SB:0] t;
    p = c * wt;
    t = {1'b0, s} + (SB+1)'(p >> C);
    if ((p >> C) > (C+FB)'(SUM_MAX) || t > {1'b0, SUM_MAX}) return SUM_MAX;
    return t[SB-1:0];
  endfunction

  function automatic logic [C-1:0] clamp(input logic [SB-1:0] s);
    return (s > SB'({C{1'b1}})) ? {C{1'b1}} : s[C-1:0];
  endfunction

  assign in_ready  = (state == rsc_pkg::BK_IDLE);
  assign out_valid = (state == rsc_pkg::BK_EMIT);
  assign out_data  = rsc_pkg::OUT_DATA_BITS'({clamp(sum_a), clamp(sum_b),
                                              clamp(sum_g), clamp(sum_r)});
  // The transmittance only changes in ACCUM and EMIT, so it is settled while idle.
  assign tb_prod = trans * in_item.b;
  assign w_prod  = tb * cur.f;
  assign t_prod  = trans * cur.t;

  always_comb begin
    state_next = state;
    unique case (state)
      rsc_pkg::BK_IDLE:   if (in_valid) state_next = rsc_pkg::BK_WEIGHT;
      rsc_pkg::BK_WEIGHT: state_next = rsc_pkg::BK_ACCUM;
      rsc_pkg::BK_ACCUM:  state_next = cur.last ? rsc_pkg::BK_EMIT : rsc_pkg::BK_IDLE;
      rsc_pkg::BK_EMIT:   if (out_ready) state_next = rsc_pkg::BK_IDLE;
      default:            state_next = rsc_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsc_pkg::BK_IDLE;
      sum_r <= '0;
      sum_g <= '0;
      sum_b <= '0;
      sum_a <= SB'(1) << C;
      trans <= TB'(1) << C;
    end else begin
      state <= state_next;
      case (state)
        rsc_pkg::BK_IDLE: if (in_valid) begin
          cur <= in_item;
          tb  <= tb_prod[C +: TB];
        end
        rsc_pkg::BK_WEIGHT: begin
          w <= w_prod[C +: FB];
        end
        rsc_pkg::BK_ACCUM: begin
          sum_r <= acc(sum_r, cur.red,   w);
          sum_g <= acc(sum_g, cur.green, w);
          sum_b <= acc(sum_b, cur.blue,  w);
          sum_a <= acc(sum_a, cur.alpha, w);
          if (cur.t != '0) trans <= t_prod[C +: TB];
        end
        rsc_pkg::BK_EMIT: if (out_ready) begin
          sum_r <= '0;
          sum_g <= '0;
          sum_b <= '0;
          sum_a <= SB'(1) << C;
          trans <= TB'(1) << C;
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- hdl/ray_segment_compositor.sv -----
`timescale 1ns / 1ps
// The front part holds a sample through the integer power, the eight square roots,
// the divide and the hand-off, plus any wait for the queue; the back part then takes
// it from the queue, weights and accumulates it and, on the last sample, emits the
// pixel. The front part takes no new sample until it has handed the last one on, as
// its bit-serial square roots and divider work on one sample at a time. rst is
// synchronous and active high; it returns the sums to (0, 0, 0, 1) and the
// transmittance to one.
module ray_segment_compositor (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // tdata from bit 0: red, green, blue, alpha, segment_depth
  input  logic [rsc_pkg::IN_DATA_BITS-1:0] s_tdata,
  input  logic s_tlast,
  output logic m_tvalid,
  input  logic m_tready,
  // tdata from bit 0: pixel_red, pixel_green, pixel_blue, pixel_alpha
  output logic [rsc_pkg::OUT_DATA_BITS-1:0] m_tdata
);
  localparam int C = rsc_pkg::C;
  rsc_pkg::sample_t fq_item, qb_item;
  logic fq_valid, fq_ready, qb_valid, qb_ready;

  // The front part turns each request into a classified sample.
  rsc_front u_front (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready),
    .red(s_tdata[0 +: C]), .green(s_tdata[C +: C]),
    .blue(s_tdata[2*C +: C]), .alpha(s_tdata[3*C +: C]),
    .segment_depth(s_tdata[4*C +: rsc_pkg::DEPTH_BITS]),
    .last_sample(s_tlast),
    .out_valid(fq_valid), .out_ready(fq_ready), .out_item(fq_item)
  );

  rsc_queue u_queue (
    .clk, .rst,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_item(fq_item),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_item(qb_item)
  );

  // The back part owns the sums and emits the pixel.
  rsc_back u_back (
    .clk, .rst,
    .in_valid(qb_valid), .in_ready(qb_ready), .in_item(qb_item),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
  );
endmodule

// ----- hdl/rsc_checker.sv -----
`timescale 1ns / 1ps
module rsc_checker (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [rsc_pkg::OUT_DATA_BITS-1:0] m_tdata
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output changed");
  a_no_out_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid) else $error("output after reset");
  a_no_in_reset: assert property (@(posedge clk)
    rst |=> s_tready) else $error("input not ready after reset");
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("input ready right after a request");
endmodule

bind ray_segment_compositor rsc_checker u_checker (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
